// File: hdl/sktl_pkg.sv
// Shared types, constants and controller/datapath command codes for the
// sorted key table lookup block. No dependencies.
`default_nettype none

package sktl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;
    localparam int KEY_W       = 63;
    localparam int VAL_W       = 32;
    localparam int WORD_W      = KEY_W + VAL_W;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SORT   = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        entry_index;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        low_bound;
        logic [IDX_W-1:0]        high_bound;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] found_value;
        logic                    duplicate_error;
    } out_item_t;

    typedef enum logic [2:0] {
        RA_LO, RA_HI, RA_MID, RA_I, RA_IM1, RA_JM1
    } rd_addr_t;

    typedef enum logic [1:0] {
        WS_ITEM, WS_SHIFT, WS_HOLD
    } wr_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOAD_ITEM, ACT_SORT_INIT, ACT_HOLD_LOAD, ACT_J_DEC,
        ACT_I_INC, ACT_PREV_LOAD, ACT_SCAN_INIT, ACT_DUP_CHK, ACT_LO_MID,
        ACT_HI_MID
    } act_t;

    typedef enum logic [2:0] {
        RES_NONE, RES_ZERO, RES_PREV, RES_RD, RES_DUP
    } res_t;

    typedef struct packed {
        logic     rd_en;
        rd_addr_t rd_addr;
        logic     wr_en;
        wr_sel_t  wr_sel;
        act_t     act;
        res_t     res;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic key_lt_prev;
        logic key_eq_prev;
        logic key_eq_rd;
        logic key_gt_rd;
        logic key_lt_rd;
        logic i_lt_n;
        logic j_zero;
        logic window_wide;
    } sts_t;

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_RD_LO, S_RD_HI, S_CHK_ENDS, S_MID_RD, S_MID_CHK,
        S_MID_TEST, S_SORT_INIT, S_OUTER, S_HOLD, S_INNER, S_CMP, S_PLACE,
        S_SCAN_INIT, S_SCAN_RD0, S_SCAN_RD1, S_SCAN_CMP, S_OUT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/sktl_datapath.sv
// Datapath of the sorted key table: table memory, working registers,
// comparators and result registers. Depends on sktl_pkg.
`default_nettype none

module sktl_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sktl_pkg::in_item_t in_item,
    input  wire logic               cfg_write_en,
    input  wire logic [10:0]        cfg_write_data,
    input  wire sktl_pkg::cmd_t     cmd,
    output sktl_pkg::sts_t          sts,
    output sktl_pkg::out_item_t     out_item
);
    import sktl_pkg::*;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]  entry_count_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [IDX_W-1:0]  widx_reg;
    logic [ADDR_W-1:0] lo_reg, hi_reg;
    logic [CNT_W-1:0]  i_reg, j_reg, n_reg;
    logic [KEY_W-1:0]  prev_key_reg;
    logic [VAL_W-1:0]  prev_val_reg;
    logic [WORD_W-1:0] rd_reg;
    logic              dup_reg;
    logic              res_found_reg;
    logic [VAL_W-1:0]  res_val_reg;
    logic              res_dup_reg;
    out_item_t         out_reg;

    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_val;
    logic [ADDR_W:0]   mid_sum;
    logic [ADDR_W-1:0] mid;
    logic [CNT_W-1:0]  i_m1, j_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign rd_key  = rd_reg[WORD_W-1:VAL_W];
    assign rd_val  = rd_reg[VAL_W-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[ADDR_W:1];
    assign i_m1    = i_reg - CNT_W'(1);
    assign j_m1    = j_reg - CNT_W'(1);

    always_comb
    begin
        unique case (cmd.rd_addr)
            RA_LO:   rd_addr = lo_reg;
            RA_HI:   rd_addr = hi_reg;
            RA_MID:  rd_addr = mid;
            RA_I:    rd_addr = i_reg[ADDR_W-1:0];
            RA_IM1:  rd_addr = i_m1[ADDR_W-1:0];
            RA_JM1:  rd_addr = j_m1[ADDR_W-1:0];
            default: rd_addr = lo_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WS_ITEM:
            begin
                wr_addr = widx_reg[ADDR_W-1:0];
                wr_data = {key_reg, val_reg};
            end
            WS_SHIFT:
            begin
                wr_addr = j_reg[ADDR_W-1:0];
                wr_data = rd_reg;
            end
            default:
            begin
                wr_addr = j_reg[ADDR_W-1:0];
                wr_data = {key_reg, val_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= CNT_W'(1);
        else if (cfg_write_en)
            entry_count_reg <= cfg_write_data;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.act)
            ACT_LOAD_ITEM:
            begin
                key_reg  <= in_item.key;
                val_reg  <= in_item.value;
                widx_reg <= in_item.entry_index;
                lo_reg   <= in_item.low_bound[ADDR_W-1:0];
                hi_reg   <= in_item.high_bound[ADDR_W-1:0];
            end
            ACT_SORT_INIT:
            begin
                i_reg   <= CNT_W'(1);
                dup_reg <= 1'b0;
                n_reg   <= (entry_count_reg > CNT_W'(TABLE_DEPTH)) ?
                           CNT_W'(TABLE_DEPTH) : entry_count_reg;
            end
            ACT_HOLD_LOAD:
            begin
                key_reg <= rd_key;
                val_reg <= rd_val;
                j_reg   <= i_reg;
            end
            ACT_J_DEC:     j_reg <= j_m1;
            ACT_I_INC:     i_reg <= i_reg + CNT_W'(1);
            ACT_PREV_LOAD:
            begin
                prev_key_reg <= rd_key;
                prev_val_reg <= rd_val;
            end
            ACT_SCAN_INIT: i_reg <= CNT_W'(1);
            ACT_DUP_CHK:
            begin
                if (rd_key == prev_key_reg && rd_val != prev_val_reg)
                    dup_reg <= 1'b1;
                i_reg <= i_reg + CNT_W'(1);
            end
            ACT_LO_MID:    lo_reg <= mid;
            ACT_HI_MID:    hi_reg <= mid;
            default:       ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.res)
            RES_ZERO:
            begin
                res_found_reg <= 1'b0;
                res_val_reg   <= '0;
                res_dup_reg   <= 1'b0;
            end
            RES_PREV:
            begin
                res_found_reg <= 1'b1;
                res_val_reg   <= prev_val_reg;
                res_dup_reg   <= 1'b0;
            end
            RES_RD:
            begin
                res_found_reg <= 1'b1;
                res_val_reg   <= rd_val;
                res_dup_reg   <= 1'b0;
            end
            RES_DUP:
            begin
                res_found_reg <= 1'b0;
                res_val_reg   <= '0;
                res_dup_reg   <= dup_reg;
            end
            default: ;
        endcase
        if (cmd.out_load)
            out_reg <= '{found: res_found_reg, found_value: res_val_reg,
                         duplicate_error: res_dup_reg};
    end

    assign out_item = out_reg;

    always_comb
    begin
        sts.key_lt_prev = key_reg < prev_key_reg;
        sts.key_eq_prev = key_reg == prev_key_reg;
        sts.key_eq_rd   = key_reg == rd_key;
        sts.key_gt_rd   = key_reg > rd_key;
        sts.key_lt_rd   = key_reg < rd_key;
        sts.i_lt_n      = i_reg < n_reg;
        sts.j_zero      = j_reg == '0;
        sts.window_wide = {1'b0, hi_reg} > ({1'b0, lo_reg} + (ADDR_W+1)'(1));
    end

endmodule

`default_nettype wire

// File: hdl/sktl_ctrl.sv
// Controller state machine for the sorted key table: sequences write,
// insertion sort, duplicate scan and window search. Depends on sktl_pkg.
`default_nettype none

module sktl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_op,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire sktl_pkg::sts_t sts,
    output sktl_pkg::cmd_t      cmd
);
    import sktl_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_WRITE:  state_next = S_WRITE;
                        OP_SORT:   state_next = S_SORT_INIT;
                        OP_LOOKUP: state_next = S_RD_LO;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_WRITE:     state_next = S_OUT;
            S_RD_LO:     state_next = S_RD_HI;
            S_RD_HI:     state_next = S_CHK_ENDS;
            S_CHK_ENDS:
            begin
                priority if (sts.key_lt_prev || sts.key_gt_rd)
                    state_next = S_OUT;
                else if (sts.key_eq_prev || sts.key_eq_rd)
                    state_next = S_OUT;
                else if (sts.window_wide)
                    state_next = S_MID_RD;
                else
                    state_next = S_OUT;
            end
            S_MID_RD:    state_next = S_MID_CHK;
            S_MID_CHK:   state_next = sts.key_eq_rd ? S_OUT : S_MID_TEST;
            S_MID_TEST:  state_next = sts.window_wide ? S_MID_RD : S_OUT;
            S_SORT_INIT: state_next = S_OUTER;
            S_OUTER:     state_next = sts.i_lt_n ? S_HOLD : S_SCAN_INIT;
            S_HOLD:      state_next = S_INNER;
            S_INNER:     state_next = sts.j_zero ? S_PLACE : S_CMP;
            S_CMP:       state_next = sts.key_lt_rd ? S_INNER : S_PLACE;
            S_PLACE:     state_next = S_OUTER;
            S_SCAN_INIT: state_next = S_SCAN_RD0;
            S_SCAN_RD0:  state_next = sts.i_lt_n ? S_SCAN_RD1 : S_OUT;
            S_SCAN_RD1:  state_next = S_SCAN_CMP;
            S_SCAN_CMP:  state_next = S_SCAN_RD0;
            S_OUT:       state_next = out_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '{rd_en: 1'b0, rd_addr: RA_LO, wr_en: 1'b0, wr_sel: WS_ITEM,
                act: ACT_NONE, res: RES_NONE, out_load: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act = ACT_LOAD_ITEM;
                    cmd.res = RES_ZERO;
                end
            end
            S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_ITEM;
            end
            S_RD_LO:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = RA_LO;
            end
            S_RD_HI:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = RA_HI;
                cmd.act     = ACT_PREV_LOAD;
            end
            S_CHK_ENDS:
            begin
                priority if (sts.key_lt_prev || sts.key_gt_rd)
                    cmd.res = RES_NONE;
                else if (sts.key_eq_prev)
                    cmd.res = RES_PREV;
                else if (sts.key_eq_rd)
                    cmd.res = RES_RD;
                else
                    cmd.res = RES_NONE;
            end
            S_MID_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = RA_MID;
            end
            S_MID_CHK:
            begin
                priority if (sts.key_eq_rd)
                    cmd.res = RES_RD;
                else if (sts.key_gt_rd)
                    cmd.act = ACT_LO_MID;
                else
                    cmd.act = ACT_HI_MID;
            end
            S_MID_TEST:  ;
            S_SORT_INIT: cmd.act = ACT_SORT_INIT;
            S_OUTER:
            begin
                cmd.rd_en   = sts.i_lt_n;
                cmd.rd_addr = RA_I;
            end
            S_HOLD:      cmd.act = ACT_HOLD_LOAD;
            S_INNER:
            begin
                cmd.rd_en   = !sts.j_zero;
                cmd.rd_addr = RA_JM1;
            end
            S_CMP:
            begin
                if (sts.key_lt_rd)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WS_SHIFT;
                    cmd.act    = ACT_J_DEC;
                end
            end
            S_PLACE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_HOLD;
                cmd.act    = ACT_I_INC;
            end
            S_SCAN_INIT: cmd.act = ACT_SCAN_INIT;
            S_SCAN_RD0:
            begin
                cmd.rd_en   = sts.i_lt_n;
                cmd.rd_addr = RA_IM1;
                if (!sts.i_lt_n)
                    cmd.res = RES_DUP;
            end
            S_SCAN_RD1:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = RA_I;
                cmd.act     = ACT_PREV_LOAD;
            end
            S_SCAN_CMP:  cmd.act = ACT_DUP_CHK;
            S_OUT:       cmd.out_load = out_free;
            default:     ;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/sorted_key_table_lookup.sv
// Top level of the sorted key table lookup block: joins controller and
// datapath. Depends on sktl_pkg, sktl_ctrl and sktl_datapath.
`default_nettype none

// Key/value table of 1024 entries with three item kinds and one result per
// item. A write item stores key and value at entry_index. A sort item orders
// entries 0..entry_count-1 (entry_count capped at 1024) by ascending key with
// a stable insertion sort on the table memory (one read and one write port),
// then scans adjacent pairs for equal keys with different values and reports
// duplicate_error. Each entry is read into a hold register, larger entries
// before it are shifted up one slot per compare, and the held entry is then
// placed; the scan reads and compares each adjacent pair. A lookup item
// reads both window end entries, rejects keys outside them, then halves the
// window with one memory read per step. Every step is bounded by the
// one-read-per-cycle table memory with its registered read data. One item is
// in work at a time; a finished result sits in the output register while the
// next item is taken. Write entry_count only while idle. Entries are not
// cleared at reset: read only written entries.
module sorted_key_table_lookup (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sktl_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sktl_pkg::out_item_t      out_item,
    input  wire logic                cfg_write_en,
    input  wire logic [10:0]         cfg_write_data
);
    import sktl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: decides every memory access and register update but the entry_count write
    sktl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_item.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table memory, working registers and output register
    sktl_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (in_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .sts            (sts),
        .out_item       (out_item)
    );

endmodule

`default_nettype wire

// File: hdl/sktl_checker.sv
// Port-level checks for sorted_key_table_lookup and the bind that attaches
// them. Depends on sktl_pkg.
`default_nettype none

module sktl_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire sktl_pkg::out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped or changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.found |-> out_item.found_value == '0)
        else $error("value nonzero without a match");

    a_found_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.found |-> !out_item.duplicate_error)
        else $error("lookup result carries duplicate flag");

    a_no_accept_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

bind sorted_key_table_lookup sktl_checker u_sktl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
